>>> src/tolm_pkg.sv
package tolm_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int NUM_ITEMS  = 256;
    localparam int STAMP_BITS = 32;

    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ITEM_AW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    // sweep counter must be able to hold NUM_ITEMS itself
    localparam int SWEEP_W = $clog2(NUM_ITEMS + 1);
    localparam int COUNT_W = 9;

    // field widths of the words on the ports
    localparam int SLOT_IN_W = 3;
    localparam int ITEM_IN_W = 8;
    localparam int STAMP_OUT_W = 32;

    localparam logic [1:0] OP_BEGIN    = 2'd0;
    localparam logic [1:0] OP_ACQUIRE  = 2'd1;
    localparam logic [1:0] OP_COMMIT   = 2'd2;
    localparam logic [1:0] OP_ROLLBACK = 2'd3;

    localparam logic [2:0] ST_GRANTED     = 3'd0;
    localparam logic [2:0] ST_SAME        = 3'd1;
    localparam logic [2:0] ST_ITEM_NEWER  = 3'd2;
    localparam logic [2:0] ST_OWNER_NEWER = 3'd3;
    localparam logic [2:0] ST_WAIT        = 3'd4;
    localparam logic [2:0] ST_RELEASED    = 3'd5;
    localparam logic [2:0] ST_BEGUN       = 3'd6;
    localparam logic [2:0] ST_EXHAUSTED   = 3'd7;

    typedef logic [STAMP_BITS-1:0] stamp_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [SLOT_IN_W-1:0] tx_slot;
        logic [ITEM_IN_W-1:0] item_index;
    } req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [STAMP_OUT_W-1:0] stamp;
        logic [COUNT_W-1:0]     released_count;
    } resp_t;

    // write request into the item table
    typedef struct packed {
        logic               en;
        logic [ITEM_AW-1:0] addr;
        logic [SLOT_AW-1:0] owner;
        stamp_t             last_stamp;
    } item_wr_t;

    // registered read result of the item table
    typedef struct packed {
        logic               own_vld;
        logic [SLOT_AW-1:0] owner;
        stamp_t             last_stamp;
    } item_rd_t;

    typedef logic [(1 << SLOT_IN_W)-1:0][SLOT_AW-1:0] slot_map_t;
    typedef logic [(1 << ITEM_IN_W)-1:0][ITEM_AW-1:0] item_map_t;

    function automatic slot_map_t gen_slot_map();
        slot_map_t m;
        for (int i = 0; i < (1 << SLOT_IN_W); i++) begin
            m[i] = SLOT_AW'(i % NUM_SLOTS);
        end
        return m;
    endfunction

    function automatic item_map_t gen_item_map();
        item_map_t m;
        for (int i = 0; i < (1 << ITEM_IN_W); i++) begin
            m[i] = ITEM_AW'(i % NUM_ITEMS);
        end
        return m;
    endfunction

    // port index folded into range
    localparam slot_map_t SLOT_MAP = gen_slot_map();
    localparam item_map_t ITEM_MAP = gen_item_map();

endpackage

>>> src/tolm_item_mem.sv
module tolm_item_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [tolm_pkg::ITEM_AW-1:0] rd_addr,
    output tolm_pkg::item_rd_t rd_data,
    input  tolm_pkg::item_wr_t wr,
    input  logic               clr_en,
    input  logic [tolm_pkg::ITEM_AW-1:0] clr_addr
);
    import tolm_pkg::*;

    typedef struct packed {
        logic [SLOT_AW-1:0] owner;
        stamp_t             last_stamp;
    } entry_t;

    entry_t             mem [NUM_ITEMS];
    logic [NUM_ITEMS-1:0] own_vld_reg;   // item currently held
    logic [NUM_ITEMS-1:0] ent_vld_reg;   // entry written at least once
    entry_t             rd_entry_reg;
    logic               rd_own_vld_reg;
    logic               rd_ent_vld_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_vld_reg    <= '0;
            ent_vld_reg    <= '0;
            rd_own_vld_reg <= 1'b0;
            rd_ent_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                own_vld_reg[wr.addr] <= 1'b1;
                ent_vld_reg[wr.addr] <= 1'b1;
            end
            if (clr_en) begin
                own_vld_reg[clr_addr] <= 1'b0;
            end
            if (rd_en) begin
                rd_own_vld_reg <= own_vld_reg[rd_addr];
                rd_ent_vld_reg <= ent_vld_reg[rd_addr];
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= '{owner: wr.owner, last_stamp: wr.last_stamp};
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_data.own_vld    = rd_own_vld_reg;
    assign rd_data.owner      = rd_entry_reg.owner;
    assign rd_data.last_stamp = rd_ent_vld_reg ? rd_entry_reg.last_stamp : '0;

endmodule

>>> src/timestamp_ordered_lock_manager_core.sv
// Wait-die lock manager. Each request word (begin, acquire, commit, rollback)
// gives exactly one result word. Begin passes through S_BEGIN to the result
// register; acquire passes through S_ACQ1, and then S_ACQ2 when another slot
// holds the item and its stamp must be fetched; commit and rollback sweep the
// whole item table in S_REL, one entry read per cycle.
// These steps are set by the registered reads of the item and slot
// memories and by the single read port used for the release sweep. Requests
// are taken one at a time; the next request is accepted once the previous
// result sits in the output register, even if the sink has not taken it yet.
// Out-of-range slots and items are folded modulo the table sizes; the stamp
// counter saturates and begin then reports exhaustion.
module timestamp_ordered_lock_manager_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tolm_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tolm_pkg::resp_t m_data
);
    import tolm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BEGIN,
        S_ACQ1,
        S_ACQ2,
        S_REL,
        S_RESP
    } state_t;

    state_t state_reg;

    // request latched at acceptance
    logic [SLOT_AW-1:0] slot_reg;
    logic [ITEM_AW-1:0] item_reg;

    // global stamp counter and requester stamp
    stamp_t counter_reg;
    stamp_t counter_inc;
    stamp_t mine_reg;

    // slot stamp memory, with per-slot written flags (reset reads as zero)
    stamp_t             slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_vld_reg;
    stamp_t             slot_rd_reg;
    logic               slot_rd_vld_reg;
    stamp_t             slot_rd_stamp;
    logic               slot_rd_en;
    logic [SLOT_AW-1:0] slot_rd_addr;
    logic               slot_wr_en;

    // release sweep
    logic [SWEEP_W-1:0] sweep_reg;
    logic               sweep_more;
    logic               pend_reg;
    logic [ITEM_AW-1:0] pend_idx_reg;
    logic [COUNT_W-1:0] count_reg;

    // result staging and output register
    resp_t result_reg;
    resp_t m_data_reg;
    logic  m_valid_reg;
    logic  out_load;

    // item table interface
    logic               item_rd_en;
    logic [ITEM_AW-1:0] item_rd_addr;
    item_rd_t           item_rd;
    item_wr_t           item_wr;
    logic               clr_en;

    logic               accept;
    logic [SLOT_AW-1:0] slot_in;
    logic [ITEM_AW-1:0] item_in;
    logic               grant_free;

    function automatic resp_t make_resp(logic [2:0] st, stamp_t stp,
                                        logic [COUNT_W-1:0] cnt);
        resp_t r;
        r.status         = st;
        r.stamp          = STAMP_OUT_W'(stp);
        r.released_count = cnt;
        return r;
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign slot_in = SLOT_MAP[s_data.tx_slot];
    assign item_in = ITEM_MAP[s_data.item_index];

    assign counter_inc = counter_reg + stamp_t'(1);

    // staged result moves to the output register once it is free
    assign out_load = (state_reg == S_RESP) && (!m_valid_reg || m_ready);

    // slot memory port: requester stamp at acceptance, holder stamp after
    // the item entry is known
    assign slot_rd_en    = accept || (state_reg == S_ACQ1);
    assign slot_rd_addr  = (state_reg == S_ACQ1) ? item_rd.owner : slot_in;
    assign slot_rd_stamp = slot_rd_vld_reg ? slot_rd_reg : '0;
    assign slot_wr_en    = (state_reg == S_BEGIN) && (counter_reg != '1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg    <= '0;
            slot_rd_vld_reg <= 1'b0;
        end else begin
            if (slot_wr_en) begin
                slot_vld_reg[slot_reg] <= 1'b1;
            end
            if (slot_rd_en) begin
                slot_rd_vld_reg <= slot_vld_reg[slot_rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_wr_en) begin
            slot_mem[slot_reg] <= counter_inc;
        end
        if (slot_rd_en) begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
    end

    // item table port: request item at acceptance, one entry a cycle during release
    assign sweep_more   = (sweep_reg < SWEEP_W'(NUM_ITEMS));
    assign item_rd_en   = accept || ((state_reg == S_REL) && sweep_more);
    assign item_rd_addr = (state_reg == S_REL) ? sweep_reg[ITEM_AW-1:0] : item_in;

    // free item: take ownership; the stamp moves only when the request wins
    assign grant_free         = slot_rd_stamp > item_rd.last_stamp;
    assign item_wr.en         = (state_reg == S_ACQ1) && !item_rd.own_vld;
    assign item_wr.addr       = item_reg;
    assign item_wr.owner      = slot_reg;
    assign item_wr.last_stamp = grant_free ? slot_rd_stamp : item_rd.last_stamp;

    assign clr_en = (state_reg == S_REL) && pend_reg && item_rd.own_vld
                    && (item_rd.owner == slot_reg);

    tolm_item_mem u_item_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (item_rd_en),
        .rd_addr  (item_rd_addr),
        .rd_data  (item_rd),
        .wr       (item_wr),
        .clr_en   (clr_en),
        .clr_addr (pend_idx_reg)
    );

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
            sweep_reg   <= '0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        slot_reg <= slot_in;
                        item_reg <= item_in;
                        unique case (s_data.opcode)
                            OP_BEGIN:   state_reg <= S_BEGIN;
                            OP_ACQUIRE: state_reg <= S_ACQ1;
                            default: begin
                                // commit and rollback both release
                                sweep_reg <= '0;
                                pend_reg  <= 1'b0;
                                count_reg <= '0;
                                state_reg <= S_REL;
                            end
                        endcase
                    end
                end
                S_BEGIN: begin
                    if (counter_reg == '1) begin
                        result_reg <= make_resp(ST_EXHAUSTED, counter_reg, '0);
                    end else begin
                        counter_reg <= counter_inc;
                        result_reg  <= make_resp(ST_BEGUN, counter_inc, '0);
                    end
                    state_reg <= S_RESP;
                end
                S_ACQ1: begin
                    mine_reg <= slot_rd_stamp;
                    priority if (!item_rd.own_vld) begin
                        if (grant_free) begin
                            result_reg <= make_resp(ST_GRANTED, '0, '0);
                        end else begin
                            result_reg <= make_resp(ST_ITEM_NEWER, item_rd.last_stamp, '0);
                        end
                        state_reg <= S_RESP;
                    end else if (item_rd.owner == slot_reg) begin
                        result_reg <= make_resp(ST_SAME, '0, '0);
                        state_reg  <= S_RESP;
                    end else begin
                        // holder stamp arrives next cycle
                        state_reg <= S_ACQ2;
                    end
                end
                S_ACQ2: begin
                    // die when the holder is newer, otherwise wait
                    if (slot_rd_stamp > mine_reg) begin
                        result_reg <= make_resp(ST_OWNER_NEWER, item_rd.last_stamp, '0);
                    end else begin
                        result_reg <= make_resp(ST_WAIT, '0, '0);
                    end
                    state_reg <= S_RESP;
                end
                S_REL: begin
                    if (sweep_more) begin
                        sweep_reg    <= sweep_reg + SWEEP_W'(1);
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= sweep_reg[ITEM_AW-1:0];
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (clr_en && (count_reg != '1)) begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    if (!sweep_more && !pend_reg) begin
                        result_reg <= make_resp(ST_RELEASED, '0, count_reg);
                        state_reg  <= S_RESP;
                    end
                end
                S_RESP: begin
                    // wait for the output register to free up
                    if (out_load) begin
                        m_data_reg <= result_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_write_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(item_wr.en && clr_en))
        else $error("item table written and cleared in the same cycle");

    a_count_only_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.released_count != '0) |-> m_data.status == ST_RELEASED)
        else $error("release count on a non-release result");

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BEGIN) && (counter_reg != '1) |=> counter_reg == $past(counter_inc))
        else $error("stamp counter did not advance on begin");

    a_sweep_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REL) && !sweep_more && !pend_reg |=> state_reg == S_RESP)
        else $error("release sweep did not finish");
`endif

endmodule

>>> tb/tolm_result_checker.sv
`timescale 1ns / 1ps

module tolm_result_checker
    import tolm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  req_t  s_data,
    input  logic  m_valid,
    input  logic  m_ready,
    input  resp_t m_data,
    output int    mismatch_count,
    output int    words_pending
);

    // shadow of the lock table
    stamp_t stamp_counter;
    stamp_t slot_stamp [NUM_SLOTS];
    logic   item_held  [NUM_ITEMS];
    int     item_holder [NUM_ITEMS];
    stamp_t item_last  [NUM_ITEMS];

    resp_t  expected_results [$];

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic resp_t lock_table_outcome(input req_t req);
        resp_t  r;
        int     slot;
        int     item;
        int     holder;
        int     count;
        stamp_t mine;
        r    = '0;
        slot = int'(req.tx_slot) % NUM_SLOTS;
        item = int'(req.item_index) % NUM_ITEMS;
        mine = slot_stamp[slot];
        case (req.opcode)
            OP_BEGIN: begin
                if (stamp_counter == {STAMP_BITS{1'b1}}) begin
                    r.status = ST_EXHAUSTED;
                    r.stamp  = STAMP_OUT_W'(stamp_counter);
                end else begin
                    stamp_counter    = stamp_counter + 1'b1;
                    slot_stamp[slot] = stamp_counter;
                    r.status         = ST_BEGUN;
                    r.stamp          = STAMP_OUT_W'(stamp_counter);
                end
            end
            OP_ACQUIRE: begin
                if (!item_held[item]) begin
                    // owner is taken even when the stamp check refuses
                    item_held[item]   = 1'b1;
                    item_holder[item] = slot;
                    if (mine > item_last[item]) begin
                        item_last[item] = mine;
                        r.status        = ST_GRANTED;
                    end else begin
                        r.status = ST_ITEM_NEWER;
                        r.stamp  = STAMP_OUT_W'(item_last[item]);
                    end
                end else if (item_holder[item] == slot) begin
                    r.status = ST_SAME;
                end else begin
                    holder = item_holder[item] % NUM_SLOTS;
                    if (slot_stamp[holder] > mine) begin
                        r.status = ST_OWNER_NEWER;
                        r.stamp  = STAMP_OUT_W'(item_last[item]);
                    end else begin
                        r.status = ST_WAIT;
                    end
                end
            end
            default: begin
                count = 0;
                for (int i = 0; i < NUM_ITEMS; i++) begin
                    if (item_held[i] && item_holder[i] == slot) begin
                        item_held[i]   = 1'b0;
                        item_holder[i] = 0;
                        if (count < 511) count++;
                    end
                end
                r.status         = ST_RELEASED;
                r.released_count = COUNT_W'(count);
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        resp_t want;
        if (!aresetn) begin
            stamp_counter = '0;
            for (int i = 0; i < NUM_SLOTS; i++) slot_stamp[i] = '0;
            for (int i = 0; i < NUM_ITEMS; i++) begin
                item_held[i]   = 1'b0;
                item_holder[i] = 0;
                item_last[i]   = '0;
            end
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                // append at the tail of the expectation queue
                expected_results = {expected_results, lock_table_outcome(s_data)};
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word with none pending: %0h", m_data));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status: expected %0d got %0d",
                                                  want.status, m_data.status));
                    if (m_data.stamp !== want.stamp)
                        report_mismatch($sformatf("stamp: expected %0d got %0d",
                                                  want.stamp, m_data.stamp));
                    if (m_data.released_count !== want.released_count)
                        report_mismatch($sformatf("released_count: expected %0d got %0d",
                                                  want.released_count,
                                                  m_data.released_count));
                end
            end
        end
        words_pending = expected_results.size();
    end

endmodule

>>> tb/timestamp_ordered_lock_manager_core_tb.sv
`timescale 1ns / 1ps

module timestamp_ordered_lock_manager_core_tb;
    import tolm_pkg::*;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_data;
    logic  m_valid;
    logic  m_ready;
    resp_t m_data;

    int    mismatch_count;
    int    words_pending;

    // idle chances in percent, changed per phase
    int    send_idle_pct  = 0;
    int    sink_stall_pct = 0;

    timestamp_ordered_lock_manager_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // watches both channels, predicts each result word and compares
    tolm_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop in case the block hangs: far beyond the slowest correct run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // result sink: ready drawn fresh every falling edge
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    // one request word: optional idle gap, then hold valid until taken
    task automatic push_word(input logic [1:0] op, input int slot, input int item);
        req_t w;
        w.opcode     = op;
        w.tx_slot    = SLOT_IN_W'(slot);
        w.item_index = ITEM_IN_W'(item);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        // no gap means valid stays high straight into the next word
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    initial begin
        int         sent;
        int         pick;
        int         slot;
        int         item;
        int         run_len;
        logic [1:0] op;

        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, no idling on either side
        // slot never begun has stamp zero: refused on a fresh item, keeps it
        push_word(OP_ACQUIRE, 0, 0);
        // same slot again: already held
        push_word(OP_ACQUIRE, 0, 0);
        push_word(OP_ROLLBACK, 0, 0);
        push_word(OP_BEGIN, 0, 8'hff);
        push_word(OP_BEGIN, 7, 8'h00);
        // granted, last stamp of item 255 moves up
        push_word(OP_ACQUIRE, 0, 255);
        // older owner holds it: wait
        push_word(OP_ACQUIRE, 7, 255);
        push_word(OP_ACQUIRE, 7, 128);
        // newer owner holds it: die
        push_word(OP_ACQUIRE, 0, 128);
        push_word(OP_COMMIT, 7, 8'h55);
        // free item whose last stamp is newer: refused, ownership kept
        push_word(OP_ACQUIRE, 0, 128);
        // two never-begun slots: equal stamps give wait
        push_word(OP_ACQUIRE, 5, 10);
        push_word(OP_ACQUIRE, 6, 10);
        push_word(OP_ACQUIRE, 3, 8'haa);
        push_word(OP_ACQUIRE, 4, 8'h55);
        // release of several items, then of none
        push_word(OP_COMMIT, 0, 0);
        push_word(OP_COMMIT, 2, 8'haa);
        push_word(OP_ROLLBACK, 5, 0);
        push_word(OP_COMMIT, 6, 0);
        push_word(OP_BEGIN, 6, 0);
        push_word(OP_ACQUIRE, 6, 8'haa);
        push_word(OP_ACQUIRE, 1, 8'h55);
        push_word(OP_ROLLBACK, 3, 0);

        // random part in four idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 57;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 57;
                end
                default: begin
                    send_idle_pct  = 11;
                    sink_stall_pct = 11;
                end
            endcase
            sent = 0;
            while (sent < 125) begin
                pick = $urandom_range(99, 0);
                if (pick < 6) begin
                    // long transaction: begin, a run of acquires, one release
                    slot    = $urandom_range(7, 0);
                    run_len = $urandom_range(40, 8);
                    push_word(OP_BEGIN, slot, $urandom_range(255, 0));
                    repeat (run_len) push_word(OP_ACQUIRE, slot, $urandom_range(255, 0));
                    op = $urandom_range(1, 0) ? OP_COMMIT : OP_ROLLBACK;
                    push_word(op, slot, $urandom_range(255, 0));
                    sent += run_len + 2;
                end else begin
                    pick = $urandom_range(99, 0);
                    if (pick < 18)      op = OP_BEGIN;
                    else if (pick < 70) op = OP_ACQUIRE;
                    else if (pick < 85) op = OP_COMMIT;
                    else                op = OP_ROLLBACK;
                    // mostly a small hot set spread over high and low bits
                    if ($urandom_range(99, 0) < 70)
                        item = ($urandom_range(3, 0) << 6) | $urandom_range(3, 0);
                    else
                        item = $urandom_range(255, 0);
                    push_word(op, $urandom_range(7, 0), item);
                    sent++;
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then allow a full release sweep for anything stray
        while (words_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
